[hw/rtl/mtrr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrr_pkg
// Shared types, codes and helpers for the memory type range table.
// ----------------------------------------------------------------------------
package mtrr_pkg;

   localparam int MAX_RANGES = 32;
   localparam int IDX_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CNT_W      = $clog2(MAX_RANGES + 1);
   localparam int ADDR_W     = 52;
   localparam int END_W      = ADDR_W + 1;
   localparam int SPAN_W     = 6;
   localparam int MTYPE_W    = 3;

   localparam logic [1:0] FUNC_ADD    = 2'd0;
   localparam logic [1:0] FUNC_LOOKUP = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;

   localparam logic [MTYPE_W-1:0] MEM_UC = 3'd0;
   localparam logic [MTYPE_W-1:0] MEM_WT = 3'd4;
   localparam logic [MTYPE_W-1:0] MEM_WB = 3'd6;

   localparam logic [SPAN_W-1:0] SPAN_MAX = SPAN_W'(ADDR_W);

   typedef struct packed {
      logic [1:0]          func;
      logic [ADDR_W-1:0]   address;
      logic [SPAN_W-1:0]   span_log2;
      logic [MTYPE_W-1:0]  range_type;
      logic                fixed_kind;
   } req_type;

   typedef struct packed {
      logic [MTYPE_W-1:0]  result_type;
      logic                straddles;
      logic                table_full;
   } rsp_type;

   // lookup transaction moving down the cell row
   typedef struct packed {
      logic                valid;
      logic                done;
      logic                straddle;
      logic                found;
      logic [MTYPE_W-1:0]  acc;
      logic [MTYPE_W-1:0]  rtype;
      logic [ADDR_W-1:0]   addr;
      logic [END_W-1:0]    last;
   } token_type;

   // entry write broadcast to the row
   typedef struct packed {
      logic                new_en;
      logic                ext_en;
      logic [IDX_W-1:0]    idx;
      logic [ADDR_W-1:0]   start_addr;
      logic [END_W-1:0]    end_addr;
      logic [MTYPE_W-1:0]  mtype;
      logic                fixed;
   } cell_wr_type;

   // size in bytes, span clamped to the address width
   function automatic logic [END_W-1:0] span_size(input logic [SPAN_W-1:0] span);
      logic [SPAN_W-1:0] s;
      s = (span > SPAN_MAX) ? SPAN_MAX : span;
      return END_W'(1) << s;
   endfunction

endpackage

[hw/rtl/mtrr_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrr_cell
// One table entry plus one stage of the lookup row.
// ----------------------------------------------------------------------------
module mtrr_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [mtrr_pkg::IDX_W-1:0]          cell_index,
   input  logic [mtrr_pkg::CNT_W-1:0]          entry_count,
   input  mtrr_pkg::cell_wr_type               wr,
   input  mtrr_pkg::token_type                 tok_prev,
   output mtrr_pkg::token_type                 tok_next
);
   import mtrr_pkg::*;

   logic [ADDR_W-1:0]  start_ff;
   logic [END_W-1:0]   end_ff;
   logic [MTYPE_W-1:0] mtype_ff;
   logic               fixed_ff;
   token_type          tok_ff;
   token_type          tok_in;

   logic               live;
   logic               hit;
   logic               wt_wb;

   // entry storage, no reset (only entries below the count are visited)
   always_ff @(posedge clock) begin
      if (wr.idx == cell_index) begin
         if (wr.new_en) begin
            start_ff <= wr.start_addr;
            end_ff   <= wr.end_addr;
            mtype_ff <= wr.mtype;
            fixed_ff <= wr.fixed;
         end else if (wr.ext_en) begin
            end_ff   <= wr.end_addr;
         end
      end
   end

   assign live  = tok_prev.valid && !tok_prev.done && (CNT_W'(cell_index) < entry_count);
   assign hit   = live && (start_ff <= tok_prev.addr) && ({1'b0, tok_prev.addr} < end_ff);
   assign wt_wb = tok_prev.found &&
                  (((mtype_ff == MEM_WT) && (tok_prev.acc == MEM_WB)) ||
                   ((mtype_ff == MEM_WB) && (tok_prev.acc == MEM_WT)));

   always_comb begin
      tok_in = tok_prev;
      if (hit) begin
         if (tok_prev.last >= end_ff) begin
            tok_in.done     = 1'b1;
            tok_in.straddle = 1'b1;
         end else if (fixed_ff || (mtype_ff == MEM_UC)) begin
            tok_in.done  = 1'b1;
            tok_in.rtype = mtype_ff;
         end else begin
            tok_in.acc   = wt_wb ? MEM_WT : mtype_ff;
            tok_in.found = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.done     <= tok_in.done;
      tok_ff.straddle <= tok_in.straddle;
      tok_ff.found    <= tok_in.found;
      tok_ff.acc      <= tok_in.acc;
      tok_ff.rtype    <= tok_in.rtype;
      tok_ff.addr     <= tok_in.addr;
      tok_ff.last     <= tok_in.last;
   end

   assign tok_next = tok_ff;

endmodule

[hw/rtl/memory_type_range_table_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_type_range_table_top
// Ordered table of address ranges with memory types; add, clear, and a
// lookup that walks the stored ranges through a row of entry cells.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  req_*     in         req_valid/req_ready  mtrr_pkg::req_type
//  rsp_*     out        rsp_valid/rsp_ready  mtrr_pkg::rsp_type
//  csr_*     in         csr_wr_en            csr_wr_data (default type)
//
//  Lookup: the request is registered at launch, walks the MAX_RANGES cells,
//  then passes the result and output registers; the next request can be
//  taken in the cycle rsp_valid rises. Add, clear and unused codes pass the
//  result and output registers, with the next request taken as rsp_valid rises.
//  Sync reset clears the count, the row's transaction valids and the FSM;
//  entry contents stay undefined until written.
//  A stalled rsp_ready holds the finished result in the hold stage; one new
//  request may be taken while the output register waits.
// ----------------------------------------------------------------------------
module memory_type_range_table_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  mtrr_pkg::req_type             req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output mtrr_pkg::rsp_type             rsp_payload,
   input  logic                          csr_wr_en,
   input  logic [mtrr_pkg::MTYPE_W-1:0]  csr_wr_data
);
   import mtrr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [MTYPE_W-1:0] default_ff;
   // shadow of the last entry, used for merge checks
   logic [END_W-1:0]   tail_end_ff, tail_end_in;
   logic [MTYPE_W-1:0] tail_type_ff, tail_type_in;
   logic               tail_fixed_ff, tail_fixed_in;
   token_type          launch_ff, launch_in;
   rsp_type            res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_payload_ff, rsp_payload_in;

   cell_wr_type        wr;
   token_type          tok [MAX_RANGES+1];
   logic [MAX_RANGES:0] tok_valid_vec;

   logic               accept;
   logic [END_W-1:0]   size;
   logic [END_W-1:0]   new_end;
   logic               merge;
   logic               full;
   logic               out_free;
   token_type          tail_tok;

   assign accept   = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign size     = span_size(req_payload.span_log2);
   assign new_end  = {1'b0, req_payload.address} + size;
   assign merge    = (count_ff != '0) &&
                     (tail_type_ff == req_payload.range_type) &&
                     (tail_fixed_ff == req_payload.fixed_kind) &&
                     (tail_end_ff == {1'b0, req_payload.address});
   assign full     = (count_ff >= CNT_W'(MAX_RANGES));
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign tail_tok = tok[MAX_RANGES];

   // request decode: table writes, launch of a lookup transaction
   always_comb begin
      count_in      = count_ff;
      tail_end_in   = tail_end_ff;
      tail_type_in  = tail_type_ff;
      tail_fixed_in = tail_fixed_ff;
      launch_in     = '0;
      wr            = '0;
      wr.start_addr = req_payload.address;
      wr.end_addr   = new_end;
      wr.mtype      = req_payload.range_type;
      wr.fixed      = req_payload.fixed_kind;
      wr.idx        = count_ff[IDX_W-1:0];
      if (accept) begin
         unique case (req_payload.func)
            FUNC_ADD: begin
               if (merge) begin
                  // grow the last entry in place
                  wr.ext_en   = 1'b1;
                  wr.idx      = IDX_W'(count_ff - CNT_W'(1));
                  tail_end_in = new_end;
               end else if (!full) begin
                  wr.new_en     = 1'b1;
                  count_in      = count_ff + CNT_W'(1);
                  tail_end_in   = new_end;
                  tail_type_in  = req_payload.range_type;
                  tail_fixed_in = req_payload.fixed_kind;
               end
            end
            FUNC_LOOKUP: begin
               launch_in.valid = 1'b1;
               launch_in.addr  = req_payload.address;
               launch_in.last  = new_end - END_W'(1);
            end
            FUNC_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // sequencer and result path
   always_comb begin
      state_in       = state_ff;
      res_in         = res_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_in = '0;
               if (req_payload.func == FUNC_LOOKUP) begin
                  state_in = ST_WALK;
               end else begin
                  res_in.table_full = (req_payload.func == FUNC_ADD) && !merge && full;
                  state_in          = ST_HOLD;
               end
            end
         end
         ST_WALK: begin
            // transaction leaves the last cell: resolve the type or flag a straddle
            if (tail_tok.valid) begin
               res_in = '0;
               priority if (tail_tok.straddle) begin
                  res_in.straddles = 1'b1;
               end else if (tail_tok.done) begin
                  res_in.result_type = tail_tok.rtype;
               end else if (tail_tok.found) begin
                  res_in.result_type = tail_tok.acc;
               end else begin
                  res_in.result_type = default_ff;
               end
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_payload_in = res_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         count_ff        <= '0;
         default_ff      <= '0;
         launch_ff.valid <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         launch_ff.valid <= launch_in.valid;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_wr_en) begin
            default_ff <= csr_wr_data;
         end
      end
      launch_ff.done     <= launch_in.done;
      launch_ff.straddle <= launch_in.straddle;
      launch_ff.found    <= launch_in.found;
      launch_ff.acc      <= launch_in.acc;
      launch_ff.rtype    <= launch_in.rtype;
      launch_ff.addr     <= launch_in.addr;
      launch_ff.last     <= launch_in.last;
      tail_end_ff        <= tail_end_in;
      tail_type_ff       <= tail_type_in;
      tail_fixed_ff      <= tail_fixed_in;
      res_ff             <= res_in;
      rsp_payload_ff     <= rsp_payload_in;
   end

   // row of entry cells; the lookup transaction advances one cell per cycle
   assign tok[0]           = launch_ff;
   assign tok_valid_vec[0] = launch_ff.valid;

   for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
      mtrr_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_index  (IDX_W'(i)),
         .entry_count (count_ff),
         .wr          (wr),
         .tok_prev    (tok[i]),
         .tok_next    (tok[i+1])
      );
      assign tok_valid_vec[i+1] = tok[i+1].valid;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // at most one lookup in flight across the row
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $countones(tok_valid_vec) <= 1)
      else $error("more than one lookup transaction in the cell row");

   // a transaction only leaves the row while walking
   a_tok_in_walk: assert property (@(posedge clock) disable iff (reset)
      tail_tok.valid |-> (state_ff == ST_WALK))
      else $error("lookup left the row outside the walk state");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RANGES))
      else $error("entry count above table size");

   // a dropped add only happens with the table full
   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_HOLD) && res_ff.table_full) |-> (count_ff == CNT_W'(MAX_RANGES)))
      else $error("table_full flagged with free entries");

   // a walk ends in the hold stage on the next cycle
   a_walk_end: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WALK) && tail_tok.valid) |=> (state_ff == ST_HOLD))
      else $error("lookup result not captured");

endmodule

[verif/memory_type_range_table_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_type_range_table_top_tb
// Self-checking bench for the memory type range table. Requests are queued
// by a stimulus process, a clocked driver plays them into req_* with random
// gaps, and a clocked monitor compares every rsp_* transaction against a
// software copy of the range table that is updated at request acceptance.
// ----------------------------------------------------------------------------
module memory_type_range_table_top_tb;
   import mtrr_pkg::*;

   // Codes the package does not name
   localparam logic [1:0]         FUNC_UNUSED = 2'd3;
   localparam logic [MTYPE_W-1:0] MEM_WC      = 3'd1;
   localparam logic [MTYPE_W-1:0] MEM_WP      = 3'd5;
   localparam logic [ADDR_W-1:0]  ADDR_TOP    = '1;

   // Long enough for a lookup through every cell, with margin on top
   localparam int SETTLE_CYCLES = MAX_RANGES + 8;
   // Longest legal quiet stretch is the forced response hold-off
   localparam int IDLE_LIMIT    = 2000;
   localparam int HOLDOFF_AT    = 150;
   localparam int HOLDOFF_LEN   = 500;
   localparam int PHASE_ITEMS   = 260;

   // Ranges handed out by the stimulus, used to aim lookups and merges
   typedef struct {
      logic [ADDR_W-1:0] start_addr;
      int                span;
   } placed_range_type;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_ready;
   req_type            req_payload = '0;
   logic               rsp_valid;
   logic               rsp_ready   = 1'b0;
   rsp_type            rsp_payload;
   logic               csr_wr_en   = 1'b0;
   logic [MTYPE_W-1:0] csr_wr_data = '0;

   memory_type_range_table_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Software copy of the range table (what the block should hold)
   // -------------------------------------------------------------------------
   logic [ADDR_W-1:0]  rt_start [MAX_RANGES];
   logic [END_W-1:0]   rt_end   [MAX_RANGES];
   logic [MTYPE_W-1:0] rt_type  [MAX_RANGES];
   logic               rt_fixed [MAX_RANGES];
   int                 rt_count   = 0;
   logic [MTYPE_W-1:0] rt_default = '0;

   // Queues between the processes
   req_type          req_backlog_q[$];
   rsp_type          expected_rsp_q[$];
   placed_range_type placed_q[$];

   // Tail of the last add handed out, to build contiguous (mergeable) runs
   logic [END_W-1:0]   gen_tail_end   = '0;
   logic [MTYPE_W-1:0] gen_tail_type  = '0;
   logic               gen_tail_fixed = 1'b0;
   logic               gen_tail_ok    = 1'b0;

   // Driver / monitor pacing
   int   req_gap      = 0;
   int   req_burst    = 0;
   int   rsp_stall    = 0;
   int   rsp_burst    = 0;
   logic holdoff_done = 1'b0;
   int   idle_cycles  = 0;

   // Run statistics
   int n_add      = 0;
   int n_lookup   = 0;
   int n_clear    = 0;
   int n_unused   = 0;
   int n_full     = 0;
   int n_straddle = 0;
   int n_rsp      = 0;
   int mismatches = 0;

   // Applies one request to the table copy and returns the response it owes.
   function automatic rsp_type apply_range_op(input req_type rq);
      rsp_type            r;
      int                 s;
      int                 k;
      logic [END_W-1:0]   size;
      logic [END_W-1:0]   addr_x;
      logic [END_W-1:0]   last_byte;
      logic               found;
      logic [MTYPE_W-1:0] acc;
      r         = '0;
      // spans past the address width are clamped
      s         = (rq.span_log2 > ADDR_W) ? ADDR_W : int'(rq.span_log2);
      size      = END_W'(1) << s;
      addr_x    = {1'b0, rq.address};
      last_byte = addr_x + size - 1'b1;
      found     = 1'b0;
      acc       = MEM_UC;
      case (rq.func)
         FUNC_ADD: begin
            k = rt_count - 1;
            if (rt_count > 0 && rt_type[k] == rq.range_type &&
                rt_fixed[k] == rq.fixed_kind && rt_end[k] == addr_x) begin
               // grows the tail entry, even with the table full
               rt_end[k] = addr_x + size;
            end else if (rt_count >= MAX_RANGES) begin
               r.table_full = 1'b1;
            end else begin
               rt_start[rt_count] = rq.address;
               rt_end[rt_count]   = addr_x + size;
               rt_type[rt_count]  = rq.range_type;
               rt_fixed[rt_count] = rq.fixed_kind;
               rt_count++;
            end
         end
         FUNC_LOOKUP: begin
            for (int i = 0; i < rt_count; i++) begin
               if (addr_x >= {1'b0, rt_start[i]} && addr_x < rt_end[i]) begin
                  if (last_byte >= rt_end[i]) begin
                     r.straddles = 1'b1;
                     return r;
                  end
                  if (rt_fixed[i] || rt_type[i] == MEM_UC) begin
                     r.result_type = rt_type[i];
                     return r;
                  end
                  // WT wins over WB whichever comes first
                  if (found && ((rt_type[i] == MEM_WT && acc == MEM_WB) ||
                                (rt_type[i] == MEM_WB && acc == MEM_WT)))
                     acc = MEM_WT;
                  else
                     acc = rt_type[i];
                  found = 1'b1;
               end
            end
            r.result_type = found ? acc : rt_default;
         end
         FUNC_CLEAR: rt_count = 0;
         default: ;
      endcase
      return r;
   endfunction

   // Mostly back-to-back, some short gaps, a few long ones, and now and
   // then a stretch with no gaps at all.
   function automatic int pick_gap(inout int burst_left);
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         burst_left = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [ADDR_W-1:0] rand_addr();
      return ADDR_W'({$urandom(), $urandom()});
   endfunction

   // Weighted toward WT and WB so the precedence rule gets exercised
   function automatic logic [MTYPE_W-1:0] rand_type();
      case ($urandom_range(0, 9))
         0:       return MEM_UC;
         1:       return MEM_WC;
         2, 3:    return MEM_WT;
         4, 5:    return MEM_WB;
         6:       return MEM_WP;
         default: return MTYPE_W'($urandom_range(0, 7));
      endcase
   endfunction

   // Queues one request and tracks what the stimulus has placed so far
   function automatic void push_req(input logic [1:0] func, input logic [ADDR_W-1:0] addr,
                                    input int span, input logic [MTYPE_W-1:0] mtype,
                                    input logic fx);
      req_type          rq;
      placed_range_type pr;
      int               s;
      rq.func       = func;
      rq.address    = addr;
      rq.span_log2  = SPAN_W'(span);
      rq.range_type = mtype;
      rq.fixed_kind = fx;
      req_backlog_q.push_back(rq);
      if (func == FUNC_ADD) begin
         s             = (span > ADDR_W) ? ADDR_W : span;
         pr.start_addr = addr;
         pr.span       = s;
         placed_q.push_back(pr);
         if (placed_q.size() > 48) placed_q.delete(0);
         gen_tail_end   = {1'b0, addr} + (END_W'(1) << s);
         gen_tail_type  = mtype;
         gen_tail_fixed = fx;
         gen_tail_ok    = 1'b1;
      end else if (func == FUNC_CLEAR) begin
         placed_q.delete();
         gen_tail_ok = 1'b0;
      end
   endfunction

   // Lookup aimed inside a placed range: mostly contained spans, some that
   // run past the range end, some fully random
   function automatic void push_probe();
      placed_range_type  pr;
      logic [ADDR_W-1:0] offs;
      int                span;
      int                r;
      r = $urandom_range(0, 19);
      if (placed_q.size() == 0) begin
         push_req(FUNC_LOOKUP, rand_addr(), $urandom_range(0, 63), rand_type(),
                  1'($urandom_range(0, 1)));
         return;
      end
      pr   = placed_q[$urandom_range(0, placed_q.size() - 1)];
      offs = (r < 3) ? '0 : (rand_addr() & ((ADDR_W'(1) << pr.span) - 1'b1));
      if (r < 12) begin
         span = $urandom_range(0, pr.span);
         offs = offs & ~((ADDR_W'(1) << span) - 1'b1);
      end else if (r < 17) begin
         span = pr.span + $urandom_range(1, 3);
      end else begin
         span = $urandom_range(0, 63);
      end
      push_req(FUNC_LOOKUP, pr.start_addr + offs, span, rand_type(),
               1'($urandom_range(0, 1)));
   endfunction

   // Sender pauses here until every outstanding response is back
   task automatic wait_drained();
      do
         @(negedge clock);
      while (req_backlog_q.size() != 0 || req_valid || expected_rsp_q.size() != 0);
   endtask

   // Default type is only rewritten with the block idle
   task automatic set_default(input logic [MTYPE_W-1:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      rt_default   = value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Request driver: holds valid and payload until the transaction is taken,
   // predicts the response at the accepting edge, then waits out a gap.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : req_drive
      logic    taken;
      rsp_type want;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         taken = req_valid && req_ready;
         if (taken) begin
            want = apply_range_op(req_payload);
            expected_rsp_q.push_back(want);
            case (req_payload.func)
               FUNC_ADD:    n_add++;
               FUNC_LOOKUP: n_lookup++;
               FUNC_CLEAR:  n_clear++;
               default:     n_unused++;
            endcase
            n_full     += want.table_full;
            n_straddle += want.straddles;
            req_gap     = pick_gap(req_burst);
         end
         // a pending transaction stays put; otherwise gap, next, or idle
         if (!req_valid || taken) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (req_backlog_q.size() != 0) begin
               req_payload <= req_backlog_q.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Response monitor: checks each accepted transaction against the oldest
   // prediction and paces rsp_ready, including one long hold-off that lets
   // the block back up into its request side.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      logic    taken;
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         taken = rsp_valid && rsp_ready;
         if (taken) begin
            n_rsp++;
            if (expected_rsp_q.size() == 0) begin
               $error("response transaction with none outstanding: %p", rsp_payload);
               mismatches++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_payload.result_type !== want.result_type) begin
                  $error("result_type: expected %0d, got %0d",
                         want.result_type, rsp_payload.result_type);
                  mismatches++;
               end
               if (rsp_payload.straddles !== want.straddles) begin
                  $error("straddles: expected %0d, got %0d",
                         want.straddles, rsp_payload.straddles);
                  mismatches++;
               end
               if (rsp_payload.table_full !== want.table_full) begin
                  $error("table_full: expected %0d, got %0d",
                         want.table_full, rsp_payload.table_full);
                  mismatches++;
               end
            end
            rsp_stall = pick_gap(rsp_burst);
         end else if (rsp_stall == 0 && $urandom_range(0, 15) == 0) begin
            // occasional stall that is not tied to a transaction
            rsp_stall = pick_gap(rsp_burst);
         end
         if (!holdoff_done && n_rsp >= HOLDOFF_AT) begin
            holdoff_done = 1'b1;
            rsp_stall    = HOLDOFF_LEN;
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Ends a hung run: counts cycles in which neither channel moves
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles++;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus: directed checks first, then random phases, each under its own
   // default type.
   // -------------------------------------------------------------------------
   initial begin
      logic [MTYPE_W-1:0] phase_dflt [5];
      logic [ADDR_W-1:0]  addr;
      logic [ADDR_W-1:0]  base;
      logic [MTYPE_W-1:0] mt;
      logic [MTYPE_W-1:0] fill_type;
      logic               fx;
      logic               fill_fixed;
      int                 kind;
      int                 lg;
      int                 sel;
      phase_dflt    = '{3'd0, 3'd5, 3'd7, 3'd2, 3'd0};
      phase_dflt[3] = MTYPE_W'($urandom_range(1, 6));
      fill_type     = MEM_UC;
      fill_fixed    = 1'b0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part, default type at its top value
      set_default(3'd7);
      push_req(FUNC_LOOKUP, '0, 0, MEM_UC, 1'b0);              // empty table: default
      push_req(FUNC_UNUSED, ADDR_TOP, 63, 3'd7, 1'b1);         // unused code: all zero
      push_req(FUNC_ADD, 52'h1000, 12, MEM_WB, 1'b0);
      push_req(FUNC_ADD, 52'h2000, 12, MEM_WB, 1'b0);          // merges into the tail
      push_req(FUNC_ADD, 52'h3000, 12, MEM_WT, 1'b0);
      push_req(FUNC_LOOKUP, 52'h1800, 0, MEM_UC, 1'b0);        // WB
      push_req(FUNC_LOOKUP, 52'h2000, 13, MEM_UC, 1'b0);       // runs past the end
      push_req(FUNC_ADD, 52'h1000, 12, MEM_WT, 1'b0);
      push_req(FUNC_LOOKUP, 52'h1000, 4, MEM_UC, 1'b0);        // WB then WT: WT
      push_req(FUNC_ADD, 52'h1000, 8, MEM_WB, 1'b0);
      push_req(FUNC_LOOKUP, 52'h1000, 0, MEM_UC, 1'b0);        // WT kept against later WB
      push_req(FUNC_ADD, 52'h1000, 4, MEM_WC, 1'b0);
      push_req(FUNC_ADD, 52'h8000, 12, MEM_WP, 1'b1);
      push_req(FUNC_ADD, 52'h8000, 12, MEM_WB, 1'b0);
      push_req(FUNC_LOOKUP, 52'h8000, 0, MEM_UC, 1'b0);        // fixed wins at once
      push_req(FUNC_ADD, 52'h1000, 1, MEM_UC, 1'b0);
      push_req(FUNC_LOOKUP, 52'h1000, 0, MEM_UC, 1'b0);        // UC wins at once
      push_req(FUNC_ADD, ADDR_TOP, 0, MEM_WB, 1'b0);
      push_req(FUNC_LOOKUP, ADDR_TOP, 0, MEM_UC, 1'b0);        // top byte
      push_req(FUNC_ADD, '0, 63, MEM_WT, 1'b1);                // clamped to full space
      push_req(FUNC_LOOKUP, '0, 63, MEM_UC, 1'b0);             // clamped span fits
      push_req(FUNC_ADD, 52'h20000, 12, MEM_WB, 1'b0);
      push_req(FUNC_CLEAR, '0, 0, MEM_UC, 1'b0);
      push_req(FUNC_ADD, 52'h21000, 12, MEM_WB, 1'b0);         // must not merge after clear
      push_req(FUNC_LOOKUP, 52'h20000, 0, MEM_UC, 1'b0);       // default again

      // Random phases. Each starts only once the block has drained, so the
      // sender pauses for every outstanding response at each boundary.
      foreach (phase_dflt[p]) begin
         set_default(phase_dflt[p]);
         while (req_backlog_q.size() < PHASE_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 3) begin
               // Fill: clear, then more non-adjacent adds than entries,
               // then grow the last stored entry while the table is full
               push_req(FUNC_CLEAR, rand_addr(), 0, MEM_UC, 1'b0);
               base = rand_addr() & ~ADDR_W'(24'hFF_FFFF);
               for (int i = 0; i < MAX_RANGES + 4; i++) begin
                  mt = rand_type();
                  fx = 1'($urandom_range(0, 1));
                  if (i == MAX_RANGES - 1) begin
                     fill_type  = mt;
                     fill_fixed = fx;
                  end
                  push_req(FUNC_ADD, base + ADDR_W'(i * 8192), 12, mt, fx);
               end
               push_req(FUNC_ADD, base + ADDR_W'((MAX_RANGES - 1) * 8192 + 4096), 12,
                        fill_type, fill_fixed);
               repeat (4) push_probe();
            end else if (kind < 45) begin
               // Build: a run of adds, mostly contiguous or overlapping,
               // followed by lookups aimed at them
               if ($urandom_range(0, 3) == 0)
                  push_req(FUNC_CLEAR, rand_addr(), $urandom_range(0, 63), rand_type(), 1'b0);
               repeat ($urandom_range(1, 6)) begin
                  lg  = ($urandom_range(0, 11) == 0) ? $urandom_range(17, 63)
                                                     : $urandom_range(0, 16);
                  sel = $urandom_range(0, 9);
                  if (sel < 5 && gen_tail_ok && !gen_tail_end[ADDR_W]) begin
                     addr = gen_tail_end[ADDR_W-1:0];
                     mt   = ($urandom_range(0, 3) != 0) ? gen_tail_type : rand_type();
                     fx   = ($urandom_range(0, 4) != 0) ? gen_tail_fixed : !gen_tail_fixed;
                  end else if (sel < 8 && placed_q.size() != 0) begin
                     addr = placed_q[$urandom_range(0, placed_q.size() - 1)].start_addr;
                     mt   = rand_type();
                     fx   = ($urandom_range(0, 4) == 0);
                  end else begin
                     addr = rand_addr();
                     mt   = rand_type();
                     fx   = ($urandom_range(0, 4) == 0);
                  end
                  push_req(FUNC_ADD, addr, lg, mt, fx);
               end
               repeat ($urandom_range(1, 5)) push_probe();
            end else if (kind < 80) begin
               repeat ($urandom_range(2, 6)) push_probe();
            end else begin
               // Noise: every field fully random, unused code included
               repeat ($urandom_range(1, 3))
                  push_req(2'($urandom_range(0, 3)), rand_addr(), $urandom_range(0, 63),
                           MTYPE_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            end
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_rsp_q.size() != 0) begin
         $error("%0d expected responses never arrived", expected_rsp_q.size());
         mismatches += expected_rsp_q.size();
      end

      $display("Drove %0d adds (%0d dropped on a full table), %0d lookups (%0d straddling),",
               n_add, n_full, n_lookup, n_straddle);
      $display("%0d clears and %0d unused codes; %0d responses checked over 6 default settings.",
               n_clear, n_unused, n_rsp);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/mtrr_pkg.sv
hw/rtl/mtrr_cell.sv
hw/rtl/memory_type_range_table_top.sv
verif/memory_type_range_table_top_tb.sv
